FILE: rtl/matrix_inverse_3x3_top_macros.svh
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_top_macros.svh
// Assertion macros shared by the checker of the 3x3 inverse block.
// ----------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_3X3_TOP_MACROS_SVH
`define MATRIX_INVERSE_3X3_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define MI3_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define MI3_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/matinv3_pkg.sv
// ----------------------------------------------------------------------------
// matinv3_pkg
// Shared widths and index helpers for the 3x3 adjugate inverse block.
// ----------------------------------------------------------------------------
package matinv3_pkg;

  localparam int ELEMENT_W = 16;  // input word field width
  localparam int INVERSE_W = 49;  // result entry width

  // Row-major position of (row, col) in a 3x3 array.
  function automatic logic [3:0] entry_index(input logic [1:0] row, input logic [1:0] col);
    return {2'b00, row} * 4'd3 + {2'b00, col};
  endfunction

  // Lower of the two rows/columns left when idx is struck out.
  function automatic logic [1:0] other_lo(input logic [1:0] idx);
    case (idx)
      2'd0:    return 2'd1;
      default: return 2'd0;
    endcase
  endfunction

  // Upper of the two rows/columns left when idx is struck out.
  function automatic logic [1:0] other_hi(input logic [1:0] idx);
    case (idx)
      2'd0, 2'd1: return 2'd2;
      default:    return 2'd1;
    endcase
  endfunction

  // Store address of operand term (0..3) of the 2x2 minor for (row, col):
  // minor = t0 * t1 - t2 * t3.
  function automatic logic [3:0] minor_addr(input logic [1:0] row, input logic [1:0] col,
                                            input logic [1:0] term);
    logic [1:0] rr;
    logic [1:0] cc;
    rr = (term == 2'd0 || term == 2'd2) ? other_lo(row) : other_hi(row);
    cc = (term == 2'd0 || term == 2'd3) ? other_lo(col) : other_hi(col);
    return entry_index(rr, cc);
  endfunction

endpackage

FILE: rtl/matinv3_in_if.sv
// ----------------------------------------------------------------------------
// matinv3_in_if
// Input channel: one signed matrix entry per word.
// ----------------------------------------------------------------------------
interface matinv3_in_if;
  import matinv3_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [ELEMENT_W-1:0] element;

  modport source(output valid, output element, input ready);
  modport sink(input valid, input element, output ready);
endinterface

FILE: rtl/matinv3_out_if.sv
// ----------------------------------------------------------------------------
// matinv3_out_if
// Result channel: one inverse entry per word, with singular and last flags.
// ----------------------------------------------------------------------------
interface matinv3_out_if;
  import matinv3_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [INVERSE_W-1:0] inverse_entry;
  logic                        singular;
  logic                        last_result;

  modport source(output valid, output inverse_entry, output singular, output last_result,
                 input ready);
  modport sink(input valid, input inverse_entry, input singular, input last_result,
               output ready);
endinterface

FILE: rtl/matinv3_ram.sv
// ----------------------------------------------------------------------------
// matinv3_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module matinv3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/matrix_inverse_3x3_top.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_top - 3x3 matrix inverse by adjugate, fixed-point result
// Loading takes one word a cycle while in LOAD; the ninth word starts the minors and
// determinant, then each entry goes through the bit-serial divider, whose quotient
// is NW = 2*ELEMENT_BITS+1+FRACTION_BITS bits wide.
// rst_n is synchronous, active low: sequencer back to loading, no result pending.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_top #(
  parameter int ELEMENT_BITS  = 16,
  parameter int FRACTION_BITS = 16
) (
  input logic           clk,
  input logic           rst_n,
  matinv3_in_if.sink    in_word,
  matinv3_out_if.source out_word
);
  import matinv3_pkg::*;

  // Datapath widths.
  localparam int CW = 2 * ELEMENT_BITS + 1;          // cofactor
  localparam int PW = ELEMENT_BITS + CW;             // multiplier product
  localparam int DW = 3 * ELEMENT_BITS + 2;          // determinant / accumulator
  localparam int NW = CW + FRACTION_BITS;            // scaled dividend / quotient
  localparam int QW = (NW + 1 > INVERSE_W) ? NW + 1 : INVERSE_W;
  localparam int SW = $clog2(NW);                    // divider step counter

  // Sequencer:
  //   LOAD      take nine words into the entry store
  //   MINOR     six steps per cofactor, two products through the shared multiplier
  //   DET       three steps per first-row term, one more to test for zero
  //   DIV_START fetch the transposed cofactor, set up the divider
  //   DIV       one quotient bit per cycle
  //   SIGN      apply the quotient sign, load the output register
  //   OUT       hold the result until it is taken
  typedef enum logic [2:0] {
    S_LOAD, S_MINOR, S_DET, S_DIV_START, S_DIV, S_SIGN, S_OUT
  } state_t;

  state_t state_r;

  logic [3:0]    load_cnt_r;
  logic [1:0]    row_r;
  logic [1:0]    col_r;
  logic [2:0]    sub_r;
  logic [SW-1:0] step_r;

  logic signed [INVERSE_W-1:0] out_entry_r;
  logic                        out_singular_r;
  logic                        out_last_r;
  logic                        out_valid_r;

  logic in_acc;
  logic out_acc;

  // Entry store.
  logic                           ram_we;
  logic [3:0]                     ram_raddr;
  logic signed [ELEMENT_BITS-1:0] ram_rdata;

  // Shared arithmetic.
  logic signed [ELEMENT_BITS-1:0] opa_r;
  logic signed [PW-1:0]           prod_r;
  logic signed [DW-1:0]           acc_r;
  logic signed [CW-1:0]           cof_r [9];
  logic [DW-1:0]                  dmag_r;
  logic                           dneg_r;
  logic                           qneg_r;
  logic [DW-1:0]                  rem_r;
  logic [NW-1:0]                  nq_r;

  logic [3:0]                     cof_rd_idx;
  logic signed [CW-1:0]           cof_rd;
  logic signed [ELEMENT_BITS-1:0] mul_a;
  logic signed [CW-1:0]           mul_b;
  logic signed [PW-1:0]           mul_p;
  logic signed [DW-1:0]           prod_ext;
  logic signed [DW-1:0]           minor_diff;
  logic signed [CW-1:0]           cof_val;
  logic signed [CW-1:0]           cof_nxt;
  logic signed [DW-1:0]           det_sum;
  logic [CW-1:0]                  cof_mag;
  logic [NW-1:0]                  nq_load;
  logic [DW-1:0]                  det_mag;
  logic [DW:0]                    div_shift;
  logic [DW:0]                    div_diff;
  logic                           div_ge;
  logic [DW-1:0]                  rem_nxt;
  logic [NW-1:0]                  nq_nxt;
  logic [QW-1:0]                  q_ext;
  logic [QW-1:0]                  q_signed;
  logic signed [INVERSE_W-1:0]    entry_nxt;

  // Handshakes. Input is open only while loading; no new matrix starts
  // until the last result of the current one is taken.
  assign in_acc  = in_word.valid && in_word.ready;
  assign out_acc = out_word.valid && out_word.ready;

  assign in_word.ready          = (state_r == S_LOAD);
  assign out_word.valid         = out_valid_r;
  assign out_word.inverse_entry = out_entry_r;
  assign out_word.singular      = out_singular_r;
  assign out_word.last_result   = out_last_r;

  // Entry store: written in row-major order while loading; read one operand
  // per cycle for minors (fixed term pattern) and for the first-row terms.
  assign ram_we    = in_acc;
  assign ram_raddr = (state_r == S_DET) ? {2'b00, col_r} : minor_addr(row_r, col_r, sub_r[1:0]);

  matinv3_ram #(
    .WIDTH (ELEMENT_BITS),
    .DEPTH (9)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (load_cnt_r),
    .wdata (in_word.element[ELEMENT_BITS-1:0]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Cofactor read: first-row cofactor during DET, else the transposed one
  // (inverse entry (i,j) uses cofactor (j,i)).
  assign cof_rd_idx = (state_r == S_DET) ? {2'b00, col_r} : entry_index(col_r, row_r);
  assign cof_rd     = cof_r[cof_rd_idx];

  // One multiplier serves both minors (entry x entry) and the determinant
  // terms (entry x cofactor).
  assign mul_a = (state_r == S_DET) ? ram_rdata : opa_r;
  assign mul_b = (state_r == S_DET) ? cof_rd
               : {{(CW - ELEMENT_BITS){ram_rdata[ELEMENT_BITS-1]}}, ram_rdata};
  assign mul_p = mul_a * mul_b;

  assign prod_ext   = {{(DW - PW){prod_r[PW-1]}}, prod_r};
  assign minor_diff = acc_r - prod_ext;
  assign cof_val    = minor_diff[CW-1:0];
  // Checkerboard sign: odd row+col negates the minor.
  assign cof_nxt    = (row_r[0] ^ col_r[0]) ? -cof_val : cof_val;
  assign det_sum    = acc_r + prod_ext;

  // Divider works on magnitudes; the quotient sign is applied at the end,
  // which gives truncation toward zero.
  assign cof_mag   = cof_rd[CW-1] ? -cof_rd : cof_rd;
  assign nq_load   = NW'(cof_mag) << FRACTION_BITS;
  assign det_mag   = acc_r[DW-1] ? -acc_r : acc_r;

  // Restoring division step: dividend bits shift out of nq_r's top while
  // quotient bits shift into its bottom.
  assign div_shift = {rem_r, nq_r[NW-1]};
  assign div_ge    = (div_shift >= {1'b0, dmag_r});
  assign div_diff  = div_shift - {1'b0, dmag_r};
  assign rem_nxt   = div_ge ? div_diff[DW-1:0] : div_shift[DW-1:0];
  assign nq_nxt    = {nq_r[NW-2:0], div_ge};

  assign q_ext     = QW'(nq_r);
  assign q_signed  = qneg_r ? -q_ext : q_ext;
  assign entry_nxt = q_signed[INVERSE_W-1:0];

  // Sequencer, counters and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      load_cnt_r  <= '0;
      row_r       <= '0;
      col_r       <= '0;
      sub_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (load_cnt_r == 4'd8) begin
              load_cnt_r <= '0;
              row_r      <= '0;
              col_r      <= '0;
              sub_r      <= '0;
              state_r    <= S_MINOR;
            end else begin
              load_cnt_r <= load_cnt_r + 4'd1;
            end
          end
        end
        S_MINOR: begin
          if (sub_r == 3'd5) begin
            sub_r <= '0;
            if (col_r == 2'd2) begin
              col_r <= '0;
              if (row_r == 2'd2) begin
                row_r   <= '0;
                state_r <= S_DET;
              end else begin
                row_r <= row_r + 2'd1;
              end
            end else begin
              col_r <= col_r + 2'd1;
            end
          end else begin
            sub_r <= sub_r + 3'd1;
          end
        end
        S_DET: begin
          if (sub_r == 3'd2) begin
            if (col_r == 2'd2) begin
              sub_r <= 3'd3;
            end else begin
              col_r <= col_r + 2'd1;
              sub_r <= '0;
            end
          end else if (sub_r == 3'd3) begin
            sub_r <= '0;
            col_r <= '0;
            row_r <= '0;
            if (acc_r == '0) begin
              // Singular: one flagged result, entry zero.
              out_entry_r    <= '0;
              out_singular_r <= 1'b1;
              out_last_r     <= 1'b1;
              out_valid_r    <= 1'b1;
              state_r        <= S_OUT;
            end else begin
              state_r <= S_DIV_START;
            end
          end else begin
            sub_r <= sub_r + 3'd1;
          end
        end
        S_DIV_START: begin
          step_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (step_r == SW'(NW - 1)) begin
            state_r <= S_SIGN;
          end else begin
            step_r <= step_r + SW'(1);
          end
        end
        S_SIGN: begin
          out_entry_r    <= entry_nxt;
          out_singular_r <= 1'b0;
          out_last_r     <= (row_r == 2'd2) && (col_r == 2'd2);
          out_valid_r    <= 1'b1;
          state_r        <= S_OUT;
        end
        S_OUT: begin
          if (out_acc) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              row_r   <= '0;
              col_r   <= '0;
              state_r <= S_LOAD;
            end else begin
              if (col_r == 2'd2) begin
                col_r <= '0;
                row_r <= row_r + 2'd1;
              end else begin
                col_r <= col_r + 2'd1;
              end
              state_r <= S_DIV_START;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  // Arithmetic registers, no reset needed.
  // Minor steps: 0 read t0 | 1 latch t0, read t1 | 2 t0*t1, read t2 |
  //              3 hold t0*t1, latch t2, read t3 | 4 t2*t3 | 5 subtract, store.
  always_ff @(posedge clk) begin
    case (state_r)
      S_MINOR: begin
        if (sub_r == 3'd1 || sub_r == 3'd3) begin
          opa_r <= ram_rdata;
        end
        if (sub_r == 3'd2 || sub_r == 3'd4) begin
          prod_r <= mul_p;
        end
        if (sub_r == 3'd3) begin
          acc_r <= prod_ext;
        end
        if (sub_r == 3'd5) begin
          cof_r[entry_index(row_r, col_r)] <= cof_nxt;
        end
      end
      S_DET: begin
        if (sub_r == 3'd0 && col_r == 2'd0) begin
          acc_r <= '0;
        end
        if (sub_r == 3'd1) begin
          prod_r <= mul_p;
        end
        if (sub_r == 3'd2) begin
          acc_r <= det_sum;
        end
        if (sub_r == 3'd3) begin
          dmag_r <= det_mag;
          dneg_r <= acc_r[DW-1];
        end
      end
      S_DIV_START: begin
        rem_r  <= '0;
        nq_r   <= nq_load;
        qneg_r <= cof_rd[CW-1] ^ dneg_r;
      end
      S_DIV: begin
        rem_r <= rem_nxt;
        nq_r  <= nq_nxt;
      end
      default: ;
    endcase
  end
endmodule

FILE: rtl/matinv3_checker.sv
// ----------------------------------------------------------------------------
// matinv3_checker
// Port-level checks for the 3x3 inverse block, bound to the top level.
// ----------------------------------------------------------------------------
`include "matrix_inverse_3x3_top_macros.svh"

module matinv3_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_singular,
  input logic out_last
);
  // A pending result is held until taken.
  `MI3_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")

  // One matrix at a time: never loading while a result is shown.
  `MI3_ASSERT_IMP(a_no_overlap, clk, rst_n, in_ready, !out_valid, "load during output")

  // A singular matrix yields exactly one word.
  `MI3_ASSERT_IMP(a_sing_last, clk, rst_n, out_valid && out_singular, out_last,
                  "singular word not last")

  // Taking the last word reopens the input at once.
  `MI3_ASSERT_NXT(a_reopen, clk, rst_n, out_valid && out_ready && out_last, in_ready,
                  "input not reopened")
endmodule

bind matrix_inverse_3x3_top matinv3_checker u_matinv3_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_word.ready),
  .out_valid    (out_word.valid),
  .out_ready    (out_word.ready),
  .out_singular (out_word.singular),
  .out_last     (out_word.last_result)
);
